[rtl/tsbg_pkg.sv]
// Shared constants, types and arithmetic helpers for the tilted surface
// beam geometry pipeline. No dependencies; every rtl file imports this.
package tsbg_pkg;

  // angle format at the ports and iteration counts
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int CORDIC_STEPS    = 16;

  // internal fixed point: signed, WF fraction bits
  localparam int WF      = 30;
  localparam int ANG_W   = 34;
  localparam int PROD_W  = 2 * ANG_W;
  localparam int SH      = WF - ANGLE_FRAC_BITS;

  // port field widths
  localparam int DAY_W       = 9;
  localparam int HRS_W       = 16;
  localparam int LAT_W       = 15;
  localparam int SLOPE_W     = 15;
  localparam int AZI_W       = 16;
  localparam int ZEN_W       = 15;
  localparam int ALT_W       = 14;
  localparam int INC_W       = 15;
  localparam int RATIO_W     = 16;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 64;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 16;

  // register map
  localparam logic [CFG_ADDR_W-1:0] REG_LATITUDE = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_SLOPE    = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] REG_AZIMUTH  = CFG_ADDR_W'(2);

  // angle constants in WF fraction bits
  localparam longint PI_L       = 64'sd3373259426;
  localparam longint TWO_PI_L   = 64'sd6746518852;
  localparam longint HALF_PI_L  = 64'sd1686629713;
  localparam longint PI_12_L    = 64'sd281104952;
  localparam longint DECL_MAX_L = 64'sd439460742;
  localparam longint GAIN_L     = 64'sd652032874;

  localparam logic signed [ANG_W-1:0] PI_Q       = ANG_W'(PI_L);
  localparam logic signed [ANG_W-1:0] TWO_PI_Q   = ANG_W'(TWO_PI_L);
  localparam logic signed [ANG_W-1:0] HALF_PI_Q  = ANG_W'(HALF_PI_L);
  localparam logic signed [ANG_W-1:0] DECL_MAX_Q = ANG_W'(DECL_MAX_L);
  localparam logic signed [ANG_W-1:0] GAIN_Q     = ANG_W'(GAIN_L);
  localparam logic signed [ANG_W-1:0] ONE_Q      = ANG_W'(1) <<< WF;

  // day of year -> angle: m*2pi/365 = m*DAY_Q + floor(m*DAY_R/365)
  localparam int     DAYS       = 365;
  localparam int     DAY_OFFSET = 284;
  localparam longint DAY_Q      = TWO_PI_L / DAYS;
  localparam int     DAY_R      = int'(TWO_PI_L % DAYS);
  localparam int     RCP_SHIFT  = 22;
  localparam int     DAY_RCP    = (1 << RCP_SHIFT) / DAYS;
  localparam int     X_W        = 16;
  localparam int     RCP_W      = 14;
  localparam int     Q0_W       = X_W + RCP_W - RCP_SHIFT;

  // hour angle from Q5.11 hours
  localparam int HRS_FRAC = 11;
  localparam int NOON     = 12 << HRS_FRAC;
  localparam int HOFF_W   = HRS_W + 2;
  localparam int HP_W     = HOFF_W + 30;

  // tilt ratio
  localparam int QB = ANGLE_FRAC_BITS + 3;
  localparam logic [QB-1:0] RMAX = QB'(5) << ANGLE_FRAC_BITS;

  // latencies in register stages
  localparam int SC_LAT    = CORDIC_STEPS + 1;
  localparam int ISQ_STEPS = WF + 1;
  localparam int ACOS_LAT  = 1 + ISQ_STEPS + 1 + CORDIC_STEPS;
  localparam int DIV_LAT   = 1 + QB;
  localparam int DIV_DLY   = ACOS_LAT - DIV_LAT;
  localparam int TOTAL_LAT = 4 + SC_LAT + 1 + SC_LAT + 5 + ACOS_LAT + 1;

  typedef struct packed {
    logic signed [ANG_W-1:0] s;
    logic signed [ANG_W-1:0] c;
  } trig_t;

  function automatic logic signed [ANG_W-1:0] atan_f(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'd843314857;
      1:  v = 32'd497837829;
      2:  v = 32'd263043837;
      3:  v = 32'd133525159;
      4:  v = 32'd67021687;
      5:  v = 32'd33543516;
      6:  v = 32'd16775851;
      7:  v = 32'd8388438;
      8:  v = 32'd4194284;
      9:  v = 32'd2097142;
      10: v = 32'd1048576;
      11: v = 32'd524288;
      12: v = 32'd262144;
      13: v = 32'd131072;
      14: v = 32'd65536;
      15: v = 32'd32768;
      16: v = 32'd16384;
      17: v = 32'd8192;
      18: v = 32'd4096;
      19: v = 32'd2048;
      20: v = 32'd1024;
      21: v = 32'd512;
      22: v = 32'd256;
      23: v = 32'd128;
      default: v = 32'd0;
    endcase
    return $signed(ANG_W'(v));
  endfunction

  // product rounded half up back to WF fraction bits
  function automatic logic signed [ANG_W-1:0] qmul(input logic signed [ANG_W-1:0] a,
                                                   input logic signed [ANG_W-1:0] b);
    logic signed [PROD_W-1:0] p;
    p = a * b;
    p = p + (PROD_W'(1) <<< (WF - 1));
    return ANG_W'(p >>> WF);
  endfunction

  function automatic logic signed [ANG_W-1:0] clamp_unit(input logic signed [ANG_W-1:0] c);
    logic signed [ANG_W-1:0] r;
    r = c;
    if (c > ONE_Q) r = ONE_Q;
    else if (c < -ONE_Q) r = -ONE_Q;
    return r;
  endfunction

  function automatic logic signed [ANG_W-1:0] round_out(input logic signed [ANG_W-1:0] a);
    logic signed [ANG_W-1:0] t;
    t = a + (ANG_W'(1) <<< (SH - 1));
    return t >>> SH;
  endfunction

endpackage

[rtl/tilted_surface_beam_geometry.sv]
// Beam geometry on a tilted surface: zenith, altitude, incidence, tilt ratio.
// Latency is set by the two CORDICs in series and the square root plus
// vectoring CORDIC. Throughput one transaction per cycle unless a full
// output stage is held.
// rst_ni clears the valid chain and the three registers to zero; a full
// output stage that is not taken stalls the whole pipeline.
module tilted_surface_beam_geometry (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // day_number[8:0], solar_hours[24:9], zero pad
  input  logic [tsbg_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // zenith_out[14:0], altitude_out[28:15], incidence_out[43:29],
  // tilt_ratio_out[59:44], zero pad
  output logic [tsbg_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [tsbg_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [tsbg_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import tsbg_pkg::*;

  logic                 en;
  logic [TOTAL_LAT-1:0] valid_q;

  logic signed [LAT_W-1:0] lat_q;
  logic [SLOPE_W-1:0]      slope_q;
  logic signed [AZI_W-1:0] azi_q;

  assign en              = ~valid_q[TOTAL_LAT-1] | m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = valid_q[TOTAL_LAT-1];
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[TOTAL_LAT-2:0], s_axis_tvalid_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_q   <= '0;
      slope_q <= '0;
      azi_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_LATITUDE: lat_q   <= $signed(cfg_data_i[LAT_W-1:0]);
        REG_SLOPE:    slope_q <= cfg_data_i[SLOPE_W-1:0];
        REG_AZIMUTH:  azi_q   <= $signed(cfg_data_i[AZI_W-1:0]);
        default: ;
      endcase
    end
  end

  // ---------------- declination argument and hour angle ----------------
  logic [DAY_W-1:0]         day;
  logic [HRS_W-1:0]         hrs;
  logic [DAY_W:0]           day_sum;
  logic [DAY_W-1:0]         m_d;
  logic signed [HOFF_W-1:0] h_off;

  assign day     = s_axis_tdata_i[DAY_W-1:0];
  assign hrs     = s_axis_tdata_i[DAY_W+HRS_W-1:DAY_W];
  assign day_sum = {1'b0, day} + (DAY_W + 1)'(DAY_OFFSET);
  assign h_off   = $signed({2'b00, hrs}) - HOFF_W'(NOON);

  always_comb begin
    if (day_sum >= (DAY_W + 1)'(2 * DAYS)) m_d = DAY_W'(day_sum - (DAY_W + 1)'(2 * DAYS));
    else if (day_sum >= (DAY_W + 1)'(DAYS)) m_d = DAY_W'(day_sum - (DAY_W + 1)'(DAYS));
    else m_d = DAY_W'(day_sum);
  end

  logic [DAY_W-1:0]        m_r1_q;
  logic signed [HP_W-1:0]  hp_r1_q;
  logic signed [ANG_W-1:0] mq_r2_q, mq_r3_q, arg_r4_q;
  logic [X_W-1:0]          x_r2_q, x_r3_q;
  logic [Q0_W-1:0]         q0_r3_q;
  logic signed [ANG_W-1:0] hr_r2_q, hr_r3_q, hr_r4_q;
  logic signed [HP_W-1:0]  hp_round;
  logic [X_W-1:0]          rem_r4;
  logic [X_W+RCP_W-1:0]    x_rcp;

  assign hp_round = hp_r1_q + (HP_W'(1) <<< (HRS_FRAC - 1));
  assign x_rcp    = (X_W + RCP_W)'(x_r2_q) * (X_W + RCP_W)'(DAY_RCP);
  assign rem_r4   = x_r3_q - X_W'(X_W'(q0_r3_q) * X_W'(DAYS));

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_r1_q  <= m_d;
      hp_r1_q <= HP_W'(h_off) * HP_W'(PI_12_L);

      mq_r2_q <= $signed(ANG_W'(m_r1_q) * ANG_W'(DAY_Q));
      x_r2_q  <= X_W'(m_r1_q) * X_W'(DAY_R);
      hr_r2_q <= ANG_W'(hp_round >>> HRS_FRAC);

      q0_r3_q <= Q0_W'(x_rcp >> RCP_SHIFT);
      mq_r3_q <= mq_r2_q;
      x_r3_q  <= x_r2_q;
      hr_r3_q <= hr_r2_q;

      // reciprocal estimate is low by at most one
      arg_r4_q <= mq_r3_q + $signed(ANG_W'(q0_r3_q))
                + $signed(ANG_W'(rem_r4 >= X_W'(DAYS)));
      hr_r4_q  <= hr_r3_q;
    end
  end

  trig_t t_day;
  tsbg_sincos u_sc_day (.clk_i(clk_i), .en_i(en), .angle_i(arg_r4_q), .trig_o(t_day));

  logic signed [ANG_W-1:0] hd_q [SC_LAT+1];
  logic signed [ANG_W-1:0] decl_r5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      hd_q[0] <= hr_r4_q;
      for (int k = 1; k <= SC_LAT; k++) hd_q[k] <= hd_q[k-1];
      decl_r5_q <= qmul(t_day.s, DECL_MAX_Q);
    end
  end

  // ---------------- five angle rotations ----------------
  logic signed [ANG_W-1:0] lat_ang, slope_ang, azi_ang;
  assign lat_ang   = ANG_W'(lat_q) <<< SH;
  assign slope_ang = $signed(ANG_W'(slope_q) << SH);
  assign azi_ang   = ANG_W'(azi_q) <<< SH;

  trig_t t_dec, t_lat, t_slp, t_azi, t_hr;
  tsbg_sincos u_sc_dec (.clk_i(clk_i), .en_i(en), .angle_i(decl_r5_q), .trig_o(t_dec));
  tsbg_sincos u_sc_lat (.clk_i(clk_i), .en_i(en), .angle_i(lat_ang), .trig_o(t_lat));
  tsbg_sincos u_sc_slp (.clk_i(clk_i), .en_i(en), .angle_i(slope_ang), .trig_o(t_slp));
  tsbg_sincos u_sc_azi (.clk_i(clk_i), .en_i(en), .angle_i(azi_ang), .trig_o(t_azi));
  tsbg_sincos u_sc_hr  (.clk_i(clk_i), .en_i(en), .angle_i(hd_q[SC_LAT]), .trig_o(t_hr));

  // ---------------- cosine sums, one product level per stage ----------------
  logic signed [ANG_W-1:0] a1_q, b1_q, e1_q, f1_q, g1_q;
  logic signed [ANG_W-1:0] cs1_q, ss1_q, ca1_q, sa1_q, ch1_q, sh1_q;
  logic signed [ANG_W-1:0] a2_q, acs2_q, bch2_q, ess2_q, bcs2_q, fss2_q, gsa2_q;
  logic signed [ANG_W-1:0] ca2_q, ch2_q, sh2_q;
  logic signed [ANG_W-1:0] cz3_q, acs3_q, essca3_q, bcsch3_q, fssca3_q, gsash3_q, ch3_q;
  logic signed [ANG_W-1:0] cz4_q, part4_q, f4_q;
  logic signed [ANG_W-1:0] cz5_q, ct5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q  <= qmul(t_dec.s, t_lat.s);
      b1_q  <= qmul(t_dec.c, t_lat.c);
      e1_q  <= qmul(t_dec.s, t_lat.c);
      f1_q  <= qmul(t_dec.c, t_lat.s);
      g1_q  <= qmul(t_dec.c, t_slp.s);
      cs1_q <= t_slp.c;
      ss1_q <= t_slp.s;
      ca1_q <= t_azi.c;
      sa1_q <= t_azi.s;
      ch1_q <= t_hr.c;
      sh1_q <= t_hr.s;

      a2_q   <= a1_q;
      acs2_q <= qmul(a1_q, cs1_q);
      bch2_q <= qmul(b1_q, ch1_q);
      ess2_q <= qmul(e1_q, ss1_q);
      bcs2_q <= qmul(b1_q, cs1_q);
      fss2_q <= qmul(f1_q, ss1_q);
      gsa2_q <= qmul(g1_q, sa1_q);
      ca2_q  <= ca1_q;
      ch2_q  <= ch1_q;
      sh2_q  <= sh1_q;

      cz3_q    <= clamp_unit(a2_q + bch2_q);
      acs3_q   <= acs2_q;
      essca3_q <= qmul(ess2_q, ca2_q);
      bcsch3_q <= qmul(bcs2_q, ch2_q);
      fssca3_q <= qmul(fss2_q, ca2_q);
      gsash3_q <= qmul(gsa2_q, sh2_q);
      ch3_q    <= ch2_q;

      cz4_q   <= cz3_q;
      part4_q <= acs3_q - essca3_q + bcsch3_q + gsash3_q;
      f4_q    <= qmul(fssca3_q, ch3_q);

      cz5_q <= cz4_q;
      ct5_q <= clamp_unit(part4_q + f4_q);
    end
  end

  // ---------------- angles and ratio ----------------
  logic signed [ANG_W-1:0] zen, inc;
  logic [QB-1:0]           ratio;

  tsbg_acos u_acos_zen (.clk_i(clk_i), .en_i(en), .cos_i(cz5_q), .angle_o(zen));
  tsbg_acos u_acos_inc (.clk_i(clk_i), .en_i(en), .cos_i(ct5_q), .angle_o(inc));
  tsbg_div  u_div (.clk_i(clk_i), .en_i(en), .ct_i(ct5_q), .cz_i(cz5_q), .ratio_o(ratio));

  logic [QB-1:0] rd_q [DIV_DLY];

  always_ff @(posedge clk_i) begin
    if (en) begin
      rd_q[0] <= ratio;
      for (int k = 1; k < DIV_DLY; k++) rd_q[k] <= rd_q[k-1];
    end
  end

  logic signed [ANG_W-1:0] alt_full, alt_pos;
  assign alt_full = HALF_PI_Q - zen;
  assign alt_pos  = (alt_full < 0) ? '0 : alt_full;

  logic [ZEN_W-1:0]   zen_q;
  logic [ALT_W-1:0]   alt_q;
  logic [INC_W-1:0]   inc_q;
  logic [RATIO_W-1:0] ratio_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      zen_q   <= ZEN_W'(round_out(zen));
      alt_q   <= ALT_W'(round_out(alt_pos));
      inc_q   <= INC_W'(round_out(inc));
      ratio_q <= RATIO_W'(rd_q[DIV_DLY-1]);
    end
  end

  assign m_axis_tdata_o = {(OUT_TDATA_W - ZEN_W - ALT_W - INC_W - RATIO_W)'(0),
                           ratio_q, inc_q, alt_q, zen_q};

endmodule

[rtl/tsbg_sincos.sv]
// Pipelined rotation CORDIC: sine and cosine of an angle, one stage per step.
// Depends on tsbg_pkg.
module tsbg_sincos (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [tsbg_pkg::ANG_W-1:0] angle_i,
  output tsbg_pkg::trig_t                  trig_o
);
  import tsbg_pkg::*;

  logic signed [ANG_W-1:0] x_q [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] y_q [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] z_q [CORDIC_STEPS+1];
  logic                    flip_q [CORDIC_STEPS+1];

  logic signed [ANG_W-1:0] wrap_a, fold_a;
  logic                    fold_flip;

  // inputs stay within one full turn, so one wrap suffices
  always_comb begin
    wrap_a = angle_i;
    if (angle_i > PI_Q) wrap_a = angle_i - TWO_PI_Q;
    else if (angle_i < -PI_Q) wrap_a = angle_i + TWO_PI_Q;
    fold_a    = wrap_a;
    fold_flip = 1'b0;
    if (wrap_a > HALF_PI_Q) begin
      fold_a    = wrap_a - PI_Q;
      fold_flip = 1'b1;
    end else if (wrap_a < -HALF_PI_Q) begin
      fold_a    = wrap_a + PI_Q;
      fold_flip = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= GAIN_Q;
      y_q[0]    <= '0;
      z_q[0]    <= fold_a;
      flip_q[0] <= fold_flip;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_f(i);
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_f(i);
        end
        flip_q[i+1] <= flip_q[i];
      end
    end
  end

  assign trig_o.s = flip_q[CORDIC_STEPS] ? -y_q[CORDIC_STEPS] : y_q[CORDIC_STEPS];
  assign trig_o.c = flip_q[CORDIC_STEPS] ? -x_q[CORDIC_STEPS] : x_q[CORDIC_STEPS];

endmodule

[rtl/tsbg_acos.sv]
// Pipelined arc cosine: square, bit-serial square root, then vectoring CORDIC.
// Depends on tsbg_pkg. Input must already lie in [-1, 1].
module tsbg_acos (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [tsbg_pkg::ANG_W-1:0] cos_i,
  output logic signed [tsbg_pkg::ANG_W-1:0] angle_o
);
  import tsbg_pkg::*;

  localparam int RAD_W = 2 * WF + 2;

  logic [RAD_W-1:0]        v_q [ISQ_STEPS+1];
  logic [RAD_W-1:0]        r_q [ISQ_STEPS+1];
  logic signed [ANG_W-1:0] c_q [ISQ_STEPS+1];

  logic signed [ANG_W-1:0] xv_q [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] yv_q [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] zv_q [CORDIC_STEPS+1];

  logic signed [PROD_W-1:0] sq, rad;
  logic signed [ANG_W-1:0]  root;

  assign sq   = cos_i * cos_i;
  assign rad  = (PROD_W'(1) <<< (2 * WF)) - sq;
  assign root = $signed(ANG_W'(r_q[ISQ_STEPS]));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q[0] <= rad[RAD_W-1:0];
      r_q[0] <= '0;
      c_q[0] <= cos_i;
      // one result bit per stage, trial bit 4^(WF-k)
      for (int k = 0; k < ISQ_STEPS; k++) begin
        if (v_q[k] >= r_q[k] + (RAD_W'(1) << (2 * WF - 2 * k))) begin
          v_q[k+1] <= v_q[k] - (r_q[k] + (RAD_W'(1) << (2 * WF - 2 * k)));
          r_q[k+1] <= (r_q[k] >> 1) + (RAD_W'(1) << (2 * WF - 2 * k));
        end else begin
          v_q[k+1] <= v_q[k];
          r_q[k+1] <= r_q[k] >> 1;
        end
        c_q[k+1] <= c_q[k];
      end

      // left half plane: rotate by a quarter turn first
      if (c_q[ISQ_STEPS] < 0) begin
        xv_q[0] <= root;
        yv_q[0] <= -c_q[ISQ_STEPS];
        zv_q[0] <= HALF_PI_Q;
      end else begin
        xv_q[0] <= c_q[ISQ_STEPS];
        yv_q[0] <= root;
        zv_q[0] <= '0;
      end

      for (int i = 0; i < CORDIC_STEPS; i++) begin
        if (yv_q[i] > 0) begin
          xv_q[i+1] <= xv_q[i] + (yv_q[i] >>> i);
          yv_q[i+1] <= yv_q[i] - (xv_q[i] >>> i);
          zv_q[i+1] <= zv_q[i] + atan_f(i);
        end else begin
          xv_q[i+1] <= xv_q[i] - (yv_q[i] >>> i);
          yv_q[i+1] <= yv_q[i] + (xv_q[i] >>> i);
          zv_q[i+1] <= zv_q[i] - atan_f(i);
        end
      end
    end
  end

  assign angle_o = (zv_q[CORDIC_STEPS] < 0) ? '0 : zv_q[CORDIC_STEPS];

endmodule

[rtl/tsbg_div.sv]
// Tilt ratio cos(incidence)/cos(zenith): sign and saturation checks, then a
// restoring divider with one quotient bit per stage. Depends on tsbg_pkg.
module tsbg_div (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [tsbg_pkg::ANG_W-1:0] ct_i,
  input  logic signed [tsbg_pkg::ANG_W-1:0] cz_i,
  output logic [tsbg_pkg::QB-1:0]          ratio_o
);
  import tsbg_pkg::*;

  localparam int REM_W = ANG_W + QB;

  logic [REM_W-1:0] rem_q [QB+1];
  logic [REM_W-1:0] den_q [QB+1];
  logic [QB-1:0]    quo_q [QB+1];
  logic             sp_q  [QB+1];
  logic [QB-1:0]    spv_q [QB+1];

  logic [ANG_W-1:0] n, d;
  logic             sp;
  logic [QB-1:0]    spv;

  assign n = ct_i < 0 ? ANG_W'(-ct_i) : ANG_W'(ct_i);
  assign d = cz_i < 0 ? ANG_W'(-cz_i) : ANG_W'(cz_i);

  always_comb begin
    sp  = 1'b0;
    spv = '0;
    if (ct_i == 0) begin
      sp = 1'b1;
    end else if (cz_i == 0) begin
      sp  = 1'b1;
      spv = (ct_i > 0) ? RMAX : '0;
    end else if ((ct_i > 0) != (cz_i > 0)) begin
      sp = 1'b1;
    end else if ({2'b00, n} >= {2'b00, d} * (ANG_W + 2)'(5)) begin
      sp  = 1'b1;
      spv = RMAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= REM_W'(n) << ANGLE_FRAC_BITS;
      den_q[0] <= REM_W'(d);
      quo_q[0] <= '0;
      sp_q[0]  <= sp;
      spv_q[0] <= spv;
      for (int k = 0; k < QB; k++) begin
        if (rem_q[k] >= (den_q[k] << (QB - 1 - k))) begin
          rem_q[k+1] <= rem_q[k] - (den_q[k] << (QB - 1 - k));
          quo_q[k+1] <= quo_q[k] | (QB'(1) << (QB - 1 - k));
        end else begin
          rem_q[k+1] <= rem_q[k];
          quo_q[k+1] <= quo_q[k];
        end
        den_q[k+1] <= den_q[k];
        sp_q[k+1]  <= sp_q[k];
        spv_q[k+1] <= spv_q[k];
      end
    end
  end

  assign ratio_o = sp_q[QB] ? spv_q[QB] : quo_q[QB];

endmodule

[rtl/tsbg_checker.sv]
// Port-level assertions for the beam geometry block, bound to the top level.
// Depends on tsbg_pkg and tilted_surface_beam_geometry.
module tsbg_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 s_axis_tready_o,
  input logic                                 m_axis_tvalid_o,
  input logic                                 m_axis_tready_i,
  input logic [tsbg_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o
);
  import tsbg_pkg::*;

  localparam logic [ZEN_W-1:0]   ZEN_HORIZON = ZEN_W'((HALF_PI_L >>> SH) + 2);
  localparam int                 ALT_LSB     = ZEN_W;
  localparam int                 RAT_LSB     = ZEN_W + ALT_W + INC_W;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // input side only stalls when the output stage is full and held
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input ready does not follow output stall");

  // valid chain is cleared by reset
  a_reset: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid_o)
    else $error("result valid during reset");

  // sun below the horizon gives zero altitude
  a_alt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[ZEN_W-1:0] >= ZEN_HORIZON)
    |-> m_axis_tdata_o[ALT_LSB+ALT_W-1:ALT_LSB] == '0)
    else $error("nonzero altitude below horizon");

  a_ratio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[RAT_LSB+RATIO_W-1:RAT_LSB] <= RATIO_W'(RMAX))
    else $error("tilt ratio above saturation");

endmodule

bind tilted_surface_beam_geometry tsbg_checker u_tsbg_checker (.*);
